### design/pdc_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the circle pair contact block.
// No dependencies; used by every module of the block.
package pdc_pkg;

	// Default width of a signed centre coordinate.
	localparam int POSITION_BITS = 24;
	// Default number of fraction bits of a unit normal component.
	localparam int NORMAL_FRACTION_BITS = 14;
	// Width of one unsigned radius.
	localparam int RADIUS_BITS = 20;
	// Width of a square root whose square is at most the squared radius sum.
	localparam int ROOT_BITS = RADIUS_BITS + 1;

endpackage

### design/pdc_sqrt_cell.sv
`timescale 1ns / 1ps
// Square root chain cell: one root bit per cycle while en is high.
// Depends on pdc_pkg for the default root width.
module pdc_sqrt_cell #(
	parameter int ROOT_W = pdc_pkg::ROOT_BITS
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [ROOT_W+1:0]     rem_in,
	input  logic [ROOT_W-1:0]     root_in,
	input  logic [2*ROOT_W-1:0]   rad_in,
	output logic [ROOT_W+1:0]     rem_out,
	output logic [ROOT_W-1:0]     root_out,
	output logic [2*ROOT_W-1:0]   rad_out
);

	logic [ROOT_W+1:0]   rem_t;
	logic [ROOT_W+1:0]   trial;
	logic                ge;
	logic [ROOT_W+1:0]   rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [2*ROOT_W-1:0] rad_q;

	// Bring down the next two radicand bits and try the next root bit.
	assign rem_t = {rem_in[ROOT_W-1:0], rad_in[2*ROOT_W-1 -: 2]};
	assign trial = {root_in, 2'b01};
	assign ge    = (rem_t >= trial);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? (rem_t - trial) : rem_t;
			root_q <= {root_in[ROOT_W-2:0], ge};
			rad_q  <= {rad_in[2*ROOT_W-3:0], 2'b00};
		end
	end

	assign rem_out  = rem_q;
	assign root_out = root_q;
	assign rad_out  = rad_q;

endmodule

### design/pdc_div_cell.sv
`timescale 1ns / 1ps
// Restoring divider chain cell: one quotient bit per cycle while en is high.
// Depends on pdc_pkg for default widths.
module pdc_div_cell #(
	parameter int DEN_W = pdc_pkg::ROOT_BITS + 1,
	parameter int QUO_W = pdc_pkg::ROOT_BITS + 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [DEN_W-1:0] den_in,
	input  logic [DEN_W-1:0] rem_in,
	input  logic [QUO_W-1:0] num_in,
	input  logic [QUO_W-1:0] quo_in,
	output logic [DEN_W-1:0] den_out,
	output logic [DEN_W-1:0] rem_out,
	output logic [QUO_W-1:0] num_out,
	output logic [QUO_W-1:0] quo_out
);

	logic [DEN_W:0]   rem_t;
	logic [DEN_W:0]   diff;
	logic             ge;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] num_q;
	logic [QUO_W-1:0] quo_q;

	assign rem_t = {rem_in, num_in[QUO_W-1]};
	assign diff  = rem_t - {1'b0, den_in};
	assign ge    = (rem_t >= {1'b0, den_in});

	always_ff @(posedge clk) begin
		if (en) begin
			den_q <= den_in;
			rem_q <= ge ? diff[DEN_W-1:0] : rem_t[DEN_W-1:0];
			num_q <= {num_in[QUO_W-2:0], 1'b0};
			quo_q <= {quo_in[QUO_W-2:0], ge};
		end
	end

	assign den_out = den_q;
	assign rem_out = rem_q;
	assign num_out = num_q;
	assign quo_out = quo_q;

endmodule

### design/pdc_div_chain.sv
`timescale 1ns / 1ps
// Pipelined unsigned divider built from a row of pdc_div_cell stages.
// Depends on pdc_pkg and pdc_div_cell.
module pdc_div_chain #(
	parameter int DEN_W = pdc_pkg::ROOT_BITS + 1,
	parameter int QUO_W = pdc_pkg::ROOT_BITS + 1
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [DEN_W-1:0]       den,
	input  logic [DEN_W+QUO_W-1:0] num,
	output logic [QUO_W-1:0]       quo
);

	logic [DEN_W-1:0] den_w [QUO_W+1];
	logic [DEN_W-1:0] rem_w [QUO_W+1];
	logic [QUO_W-1:0] num_w [QUO_W+1];
	logic [QUO_W-1:0] quo_w [QUO_W+1];

	// The top part of the numerator is already below the divisor whenever the
	// quotient fits in QUO_W bits, so it seeds the partial remainder.
	assign den_w[0] = den;
	assign rem_w[0] = num[DEN_W+QUO_W-1 -: DEN_W];
	assign num_w[0] = num[QUO_W-1:0];
	assign quo_w[0] = '0;

	for (genvar i = 0; i < QUO_W; i++) begin : g_cell
		pdc_div_cell #(
			.DEN_W(DEN_W),
			.QUO_W(QUO_W)
		) u_cell (
			.clk     (clk),
			.en      (en),
			.den_in  (den_w[i]),
			.rem_in  (rem_w[i]),
			.num_in  (num_w[i]),
			.quo_in  (quo_w[i]),
			.den_out (den_w[i+1]),
			.rem_out (rem_w[i+1]),
			.num_out (num_w[i+1]),
			.quo_out (quo_w[i+1])
		);
	end

	assign quo = quo_w[QUO_W];

endmodule

### design/circle_pair_contact.sv
`timescale 1ns / 1ps
// Top level of the circle pair contact block.
// Depends on pdc_pkg, pdc_sqrt_cell and pdc_div_chain.
//
// The block takes one circle pair per cycle while item_ready is high and
// returns one result per pair, in order. The pipeline holds the square root
// chain, one cell per root bit, and the divider chains, one cell per
// quotient bit. A result that waits at the output does not stop new pairs:
// a skid register takes one more result before the input stalls.
// Contact is decided exactly from squared distances; on a hit the contact
// point and unit normal use the centre distance rounded to the nearest step.
module circle_pair_contact #(
	parameter int POSITION_BITS        = pdc_pkg::POSITION_BITS,
	parameter int NORMAL_FRACTION_BITS = pdc_pkg::NORMAL_FRACTION_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_ready,
	input  logic signed [POSITION_BITS-1:0]        first_x,
	input  logic signed [POSITION_BITS-1:0]        first_y,
	input  logic [pdc_pkg::RADIUS_BITS-1:0]        first_radius,
	input  logic signed [POSITION_BITS-1:0]        second_x,
	input  logic signed [POSITION_BITS-1:0]        second_y,
	input  logic [pdc_pkg::RADIUS_BITS-1:0]        second_radius,
	output logic                                   result_valid,
	input  logic                                   result_ready,
	output logic                                   hit,
	output logic signed [POSITION_BITS-1:0]        contact_x,
	output logic signed [POSITION_BITS-1:0]        contact_y,
	output logic signed [NORMAL_FRACTION_BITS+1:0] normal_x,
	output logic signed [NORMAL_FRACTION_BITS+1:0] normal_y
);

	localparam int P    = POSITION_BITS;
	localparam int NFB  = NORMAL_FRACTION_BITS;
	localparam int RB   = pdc_pkg::RADIUS_BITS;
	localparam int SQ   = pdc_pkg::ROOT_BITS;
	localparam int AW   = SQ + 1;
	localparam int SQW  = 2 * P + 2;
	localparam int CW   = (SQW > 2 * SQ) ? SQW : 2 * SQ;
	localparam int QL   = (SQ + 1 > NFB + 1) ? SQ + 1 : NFB + 1;
	localparam int CDW  = SQ + 2;
	localparam int NDW  = SQ + 1;
	localparam int NB   = NFB + 2;
	localparam int NNW  = AW + NFB + 1;
	localparam int PCW  = AW + SQ + 1;
	localparam int SW   = ((P > QL + 1) ? P : QL + 1) + 1;
	localparam logic signed [P-1:0] POS_MAX = {1'b0, {(P-1){1'b1}}};
	localparam logic signed [P-1:0] POS_MIN = {1'b1, {(P-1){1'b0}}};

	typedef struct packed {
		logic signed [P-1:0]  x1;
		logic signed [P-1:0]  y1;
		logic signed [RB:0]   rdiff;
		logic [AW-1:0]        ax;
		logic [AW-1:0]        ay;
		logic                 sx;
		logic                 sy;
		logic                 hit;
		logic                 zero;
	} sq_side_t;

	typedef struct packed {
		logic signed [P-1:0] x1;
		logic signed [P-1:0] y1;
		logic                ncx;
		logic                ncy;
		logic                nnx;
		logic                nny;
		logic                hit;
		logic                zero;
	} dv_side_t;

	typedef struct packed {
		logic                  hit;
		logic signed [P-1:0]   cx;
		logic signed [P-1:0]   cy;
		logic signed [NB-1:0]  nx;
		logic signed [NB-1:0]  ny;
	} res_t;

	logic en;
	logic out_vld_q, skid_vld_q;

	// Stage 1: centre differences and radius sums.
	logic signed [P:0]  dx_s1, dy_s1;
	logic signed [P-1:0] x1_s1, y1_s1;
	logic signed [RB:0] rdiff_s1;
	logic [RB:0]        rs_s1;
	logic               nz_s1;
	logic               v_s1;

	// Stage 2: squares.
	logic [SQW-1:0]     axsq_s2, aysq_s2;
	logic [2*SQ-1:0]    rssq_s2;
	logic [AW-1:0]      ax_s2, ay_s2;
	logic               sx_s2, sy_s2;
	logic signed [P-1:0] x1_s2, y1_s2;
	logic signed [RB:0] rdiff_s2;
	logic               nz_s2;
	logic               v_s2;

	// Stage 3: squared distance and contact decision.
	logic [2*SQ-1:0]    dsq_s3;
	sq_side_t           side_s3;
	logic               v_s3;

	logic [P:0]         ax_w, ay_w;
	logic [CW-1:0]      dsq_w;

	assign en         = !skid_vld_q;
	assign item_ready = en;

	assign ax_w  = dx_s1[P] ? (P+1)'(-dx_s1) : (P+1)'(dx_s1);
	assign ay_w  = dy_s1[P] ? (P+1)'(-dy_s1) : (P+1)'(dy_s1);
	assign dsq_w = CW'(axsq_s2) + CW'(aysq_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1    <= (P+1)'(second_x) - (P+1)'(first_x);
			dy_s1    <= (P+1)'(second_y) - (P+1)'(first_y);
			x1_s1    <= first_x;
			y1_s1    <= first_y;
			rdiff_s1 <= $signed({1'b0, first_radius}) - $signed({1'b0, second_radius});
			rs_s1    <= {1'b0, first_radius} + {1'b0, second_radius};
			nz_s1    <= (first_radius != '0) && (second_radius != '0);

			axsq_s2  <= ax_w * ax_w;
			aysq_s2  <= ay_w * ay_w;
			rssq_s2  <= rs_s1 * rs_s1;
			ax_s2    <= AW'(ax_w);
			ay_s2    <= AW'(ay_w);
			sx_s2    <= dx_s1[P];
			sy_s2    <= dy_s1[P];
			x1_s2    <= x1_s1;
			y1_s2    <= y1_s1;
			rdiff_s2 <= rdiff_s1;
			nz_s2    <= nz_s1;

			dsq_s3        <= dsq_w[2*SQ-1:0];
			side_s3.x1    <= x1_s2;
			side_s3.y1    <= y1_s2;
			side_s3.rdiff <= rdiff_s2;
			side_s3.ax    <= ax_s2;
			side_s3.ay    <= ay_s2;
			side_s3.sx    <= sx_s2;
			side_s3.sy    <= sy_s2;
			side_s3.hit   <= nz_s2 && (dsq_w <= CW'(rssq_s2));
			side_s3.zero  <= (dsq_w == '0);
		end
	end

	// Square root chain, one root bit per cell.
	logic [SQ+1:0]   rem_w  [SQ+1];
	logic [SQ-1:0]   root_w [SQ+1];
	logic [2*SQ-1:0] rad_w  [SQ+1];
	sq_side_t        sq_side_q [1:SQ];
	logic            sq_vld_q  [1:SQ];

	assign rem_w[0]  = '0;
	assign root_w[0] = '0;
	assign rad_w[0]  = dsq_s3;

	for (genvar j = 0; j < SQ; j++) begin : g_sqrt
		pdc_sqrt_cell #(
			.ROOT_W(SQ)
		) u_cell (
			.clk      (clk),
			.en       (en),
			.rem_in   (rem_w[j]),
			.root_in  (root_w[j]),
			.rad_in   (rad_w[j]),
			.rem_out  (rem_w[j+1]),
			.root_out (root_w[j+1]),
			.rad_out  (rad_w[j+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= SQ; k++) begin
				sq_vld_q[k] <= 1'b0;
			end
		end else if (en) begin
			sq_vld_q[1] <= v_s3;
			for (int k = 2; k <= SQ; k++) begin
				sq_vld_q[k] <= sq_vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_side_q[1] <= side_s3;
			for (int k = 2; k <= SQ; k++) begin
				sq_side_q[k] <= sq_side_q[k-1];
			end
		end
	end

	// Stage 4: rounded distance and the contact offset factor.
	logic [NDW-1:0]      d_w;
	logic [NDW-1:0]      d_s4;
	logic signed [SQ+1:0] f_s4;
	sq_side_t            side_s4;
	logic                v_s4;

	// Round up when the floor root leaves a remainder above the root.
	assign d_w = {1'b0, root_w[SQ]} + NDW'(rem_w[SQ] > {2'b00, root_w[SQ]});

	// Stage 5: products for the contact numerators, normal numerators.
	logic [SQ:0]         fmag_w;
	logic                fneg_w;
	logic [PCW-1:0]      pcx_s5, pcy_s5;
	logic [NNW-1:0]      nnx_s5, nny_s5;
	logic [NDW-1:0]      d_s5;
	dv_side_t            side_s5;
	logic                v_s5;

	assign fneg_w = f_s4[SQ+1];
	assign fmag_w = fneg_w ? (SQ+1)'(-f_s4) : (SQ+1)'(f_s4);

	// Stage 6: rounding offsets added, divider operands.
	logic [CDW+QL-1:0]   ncx_s6, ncy_s6;
	logic [NDW+QL-1:0]   nnx_s6, nny_s6;
	logic [CDW-1:0]      den2_s6;
	logic [NDW-1:0]      den1_s6;
	dv_side_t            side_s6;
	logic                v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_vld_q[SQ];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s4    <= d_w;
			f_s4    <= (SQ+2)'(sq_side_q[SQ].rdiff) + $signed({1'b0, d_w});
			side_s4 <= sq_side_q[SQ];

			pcx_s5       <= side_s4.ax * fmag_w;
			pcy_s5       <= side_s4.ay * fmag_w;
			nnx_s5       <= (NNW'(side_s4.ax) << NFB) + NNW'(d_s4 >> 1);
			nny_s5       <= (NNW'(side_s4.ay) << NFB) + NNW'(d_s4 >> 1);
			d_s5         <= d_s4;
			side_s5.x1   <= side_s4.x1;
			side_s5.y1   <= side_s4.y1;
			side_s5.ncx  <= side_s4.sx ^ fneg_w;
			side_s5.ncy  <= side_s4.sy ^ fneg_w;
			side_s5.nnx  <= side_s4.sx;
			side_s5.nny  <= side_s4.sy;
			side_s5.hit  <= side_s4.hit;
			side_s5.zero <= side_s4.zero;

			ncx_s6  <= (CDW+QL)'(pcx_s5) + (CDW+QL)'(d_s5);
			ncy_s6  <= (CDW+QL)'(pcy_s5) + (CDW+QL)'(d_s5);
			nnx_s6  <= (NDW+QL)'(nnx_s5);
			nny_s6  <= (NDW+QL)'(nny_s5);
			den2_s6 <= {d_s5, 1'b0};
			den1_s6 <= d_s5;
			side_s6 <= side_s5;
		end
	end

	// Divider chains: contact offsets over 2d, normal components over d.
	logic [QL-1:0] qcx, qcy, qnx, qny;

	pdc_div_chain #(.DEN_W(CDW), .QUO_W(QL)) u_div_cx (
		.clk(clk), .en(en), .den(den2_s6), .num(ncx_s6), .quo(qcx)
	);
	pdc_div_chain #(.DEN_W(CDW), .QUO_W(QL)) u_div_cy (
		.clk(clk), .en(en), .den(den2_s6), .num(ncy_s6), .quo(qcy)
	);
	pdc_div_chain #(.DEN_W(NDW), .QUO_W(QL)) u_div_nx (
		.clk(clk), .en(en), .den(den1_s6), .num(nnx_s6), .quo(qnx)
	);
	pdc_div_chain #(.DEN_W(NDW), .QUO_W(QL)) u_div_ny (
		.clk(clk), .en(en), .den(den1_s6), .num(nny_s6), .quo(qny)
	);

	dv_side_t dv_side_q [1:QL];
	logic     dv_vld_q  [1:QL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= QL; k++) begin
				dv_vld_q[k] <= 1'b0;
			end
		end else if (en) begin
			dv_vld_q[1] <= v_s6;
			for (int k = 2; k <= QL; k++) begin
				dv_vld_q[k] <= dv_vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_side_q[1] <= side_s6;
			for (int k = 2; k <= QL; k++) begin
				dv_side_q[k] <= dv_side_q[k-1];
			end
		end
	end

	function automatic logic signed [P-1:0] sat_pos(input logic signed [SW-1:0] v);
		logic signed [P-1:0] r;
		if (v > SW'(POS_MAX)) begin
			r = POS_MAX;
		end else if (v < SW'(POS_MIN)) begin
			r = POS_MIN;
		end else begin
			r = P'(v);
		end
		return r;
	endfunction

	// Final result assembly from the divider outputs.
	dv_side_t              fs;
	logic signed [QL:0]    scx, scy;
	logic signed [SW-1:0]  sum_x, sum_y;
	logic signed [NB-1:0]  snx, sny;
	res_t                  fin;
	logic                  fin_vld;

	assign fs      = dv_side_q[QL];
	assign fin_vld = dv_vld_q[QL];
	assign scx     = fs.ncx ? -$signed({1'b0, qcx}) : $signed({1'b0, qcx});
	assign scy     = fs.ncy ? -$signed({1'b0, qcy}) : $signed({1'b0, qcy});
	assign sum_x   = SW'(fs.x1) + SW'(scx);
	assign sum_y   = SW'(fs.y1) + SW'(scy);
	assign snx     = fs.nnx ? -NB'(qnx) : NB'(qnx);
	assign sny     = fs.nny ? -NB'(qny) : NB'(qny);

	always_comb begin
		fin = '0;
		if (fs.hit) begin
			fin.hit = 1'b1;
			if (fs.zero) begin
				// Coincident centres: contact at the first centre, no normal.
				fin.cx = fs.x1;
				fin.cy = fs.y1;
			end else begin
				fin.cx = sat_pos(sum_x);
				fin.cy = sat_pos(sum_y);
				fin.nx = snx;
				fin.ny = sny;
			end
		end
	end

	// Output register with a skid register behind it.
	res_t out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || result_ready) begin
			out_vld_q  <= skid_vld_q || fin_vld;
			skid_vld_q <= 1'b0;
		end else if (en && fin_vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || result_ready) begin
			out_q <= skid_vld_q ? skid_q : fin;
		end else if (en && fin_vld) begin
			skid_q <= fin;
		end
	end

	assign result_valid = out_vld_q;
	assign hit          = out_q.hit;
	assign contact_x    = out_q.cx;
	assign contact_y    = out_q.cy;
	assign normal_x     = out_q.nx;
	assign normal_y     = out_q.ny;

`ifndef NO_ASSERTIONS
	localparam logic signed [NB-1:0] N_ONE  = NB'(1 << NFB);
	localparam logic signed [NB-1:0] N_MONE = -NB'(1 << NFB);

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid register holds a result while the output is empty");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (result_valid && $past(result_valid) && !$past(result_ready)))
		else $error("input stalled without a waiting result");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !hit) |->
		(contact_x == '0 && contact_y == '0 && normal_x == '0 && normal_y == '0))
		else $error("result without contact carries nonzero fields");

	a_normal_unit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (normal_x <= N_ONE && normal_x >= N_MONE &&
			normal_y <= N_ONE && normal_y >= N_MONE))
		else $error("normal component beyond unit length");
`endif

endmodule
